FILE: hw/rtl/cll_pkg.sv
// ----------------------------------------------------------------------------
// cll_pkg
// Shared constants, codes and state type for the circular list block.
// ----------------------------------------------------------------------------
`default_nettype none

package cll_pkg;

  localparam int DEPTH  = 16;
  localparam int SLOT_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);

  localparam int VAL_W  = 32;
  localparam int POS_W  = 8;
  localparam int OCNT_W = 5;
  localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam int S_TDATA_W = 48;
  localparam int M_TDATA_W = 40;

  typedef enum logic [1:0] {
    CMD_APPEND  = 2'd0,
    CMD_REMOVE  = 2'd1,
    CMD_DISPLAY = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_EMPTY   = 3'd1,
    ST_ABSENT  = 3'd2,
    ST_FULL    = 3'd3,
    ST_INVALID = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_APP_LINK,
    S_RM_HEAD,
    S_RM_HOP,
    S_RM_NEXT,
    S_DISP
  } state_t;

endpackage

`default_nettype wire

FILE: hw/rtl/cll_ram.sv
// ----------------------------------------------------------------------------
// cll_ram
// Single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cll_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: hw/rtl/circular_list_append_remove_kth.sv
// ----------------------------------------------------------------------------
// circular_list_append_remove_kth
// Ring of signed values held in a linked value/link RAM pair.
// Error statuses, an empty display and an append to an empty ring answer from
//   the execute state; other appends answer from a link-write state, remove at
//   position 1 from a head state, and other removes after walking from the head
//   to the entry before it; a display gives items in ring order from the head.
//   One command at a time, the next taken back in idle; output stalls delay it.
// Reset: ring empty, head, tail and count zero; RAM contents stay undefined.
// ----------------------------------------------------------------------------
`default_nettype none

module circular_list_append_remove_kth (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  // value [31:0], position [39:32], zero fill [47:40]
  input  wire logic [cll_pkg::S_TDATA_W-1:0] s_tdata,
  // cmd [1:0]
  input  wire logic [1:0]                    s_tuser,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  // item_value [31:0], entry_count [36:32], zero fill [39:37]
  output logic [cll_pkg::M_TDATA_W-1:0]      m_tdata,
  // status [2:0]
  output logic [2:0]                         m_tuser,
  output logic                               m_tlast
);

  cll_pkg::state_t                  state, state_next;
  cll_pkg::cmd_t                    cmd;
  logic [cll_pkg::VAL_W-1:0]        value;
  logic [cll_pkg::POS_W-1:0]        position;
  logic [cll_pkg::DEPTH-1:0]        used, used_next;
  logic [cll_pkg::SLOT_W-1:0]       head, head_next;
  logic [cll_pkg::SLOT_W-1:0]       tail, tail_next;
  logic [cll_pkg::CNT_W-1:0]        count, count_next;
  logic [cll_pkg::SLOT_W-1:0]       node, node_next;
  logic [cll_pkg::SLOT_W-1:0]       cur, cur_next;
  logic [cll_pkg::CNT_W-1:0]        hops, hops_next;
  logic [cll_pkg::CNT_W-1:0]        rem, rem_next;

  logic                             out_free;
  logic                             emit;
  cll_pkg::status_t                 e_status;
  logic [cll_pkg::VAL_W-1:0]        e_value;
  logic                             e_last;
  logic [cll_pkg::CNT_W-1:0]        e_count;

  cll_pkg::status_t                 out_status;
  logic [cll_pkg::VAL_W-1:0]        out_value;
  logic                             out_last;
  logic [cll_pkg::CNT_W-1:0]        out_count;

  logic [cll_pkg::SLOT_W-1:0]       raddr;
  logic                             lw_en, vw_en;
  logic [cll_pkg::SLOT_W-1:0]       lw_addr, vw_addr;
  logic [cll_pkg::SLOT_W-1:0]       lw_data;
  logic [cll_pkg::SLOT_W-1:0]       link_q;
  logic [cll_pkg::VAL_W-1:0]        value_q;

  logic [cll_pkg::SLOT_W-1:0]       free_slot;
  logic                             in_accept;

  cll_ram #(
    .WIDTH (cll_pkg::SLOT_W),
    .DEPTH (cll_pkg::DEPTH)
  ) u_link_ram (
    .clk   (clk),
    .we    (lw_en),
    .waddr (lw_addr),
    .wdata (lw_data),
    .raddr (raddr),
    .rdata (link_q)
  );

  cll_ram #(
    .WIDTH (cll_pkg::VAL_W),
    .DEPTH (cll_pkg::DEPTH)
  ) u_value_ram (
    .clk   (clk),
    .we    (vw_en),
    .waddr (vw_addr),
    .wdata (value),
    .raddr (raddr),
    .rdata (value_q)
  );

  assign s_tready  = (state == cll_pkg::S_IDLE);
  assign in_accept = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;

  always_comb begin
    free_slot = '0;
    for (int i = cll_pkg::DEPTH - 1; i >= 0; i--) begin
      if (!used[i]) begin
        free_slot = cll_pkg::SLOT_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cll_pkg::S_IDLE;
      used  <= '0;
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      state <= state_next;
      used  <= used_next;
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      cmd      <= cll_pkg::cmd_t'(s_tuser);
      value    <= s_tdata[cll_pkg::VAL_W-1:0];
      position <= s_tdata[cll_pkg::VAL_W +: cll_pkg::POS_W];
    end
    node <= node_next;
    cur  <= cur_next;
    hops <= hops_next;
    rem  <= rem_next;
  end

  always_comb begin
    state_next = state;
    used_next  = used;
    head_next  = head;
    tail_next  = tail;
    count_next = count;
    node_next  = node;
    cur_next   = cur;
    hops_next  = hops;
    rem_next   = rem;
    raddr      = node;
    lw_en      = 1'b0;
    lw_addr    = node;
    lw_data    = cur;
    vw_en      = 1'b0;
    vw_addr    = free_slot;
    emit       = 1'b0;
    e_status   = cll_pkg::ST_OK;
    e_value    = '0;
    e_last     = 1'b1;
    e_count    = count;

    unique case (state)
      cll_pkg::S_IDLE: begin
        if (in_accept) begin
          state_next = cll_pkg::S_EXEC;
        end
      end

      cll_pkg::S_EXEC: begin
        if (out_free) begin
          unique case (cmd)
            cll_pkg::CMD_APPEND: begin
              if (count == cll_pkg::CNT_W'(cll_pkg::DEPTH)) begin
                emit       = 1'b1;
                e_status   = cll_pkg::ST_FULL;
                state_next = cll_pkg::S_IDLE;
              end else begin
                vw_en                = 1'b1;
                lw_en                = 1'b1;
                lw_addr              = free_slot;
                lw_data              = (count == '0) ? free_slot : head;
                used_next[free_slot] = 1'b1;
                tail_next            = free_slot;
                count_next           = count + 1'b1;
                if (count == '0) begin
                  head_next  = free_slot;
                  emit       = 1'b1;
                  e_count    = count_next;
                  state_next = cll_pkg::S_IDLE;
                end else begin
                  node_next  = tail;
                  cur_next   = free_slot;
                  state_next = cll_pkg::S_APP_LINK;
                end
              end
            end
            cll_pkg::CMD_REMOVE: begin
              priority if (position == '0) begin
                emit       = 1'b1;
                e_status   = cll_pkg::ST_INVALID;
                state_next = cll_pkg::S_IDLE;
              end else if (count == '0) begin
                emit       = 1'b1;
                e_status   = cll_pkg::ST_EMPTY;
                state_next = cll_pkg::S_IDLE;
              end else if (cll_pkg::CMP_W'(position) > cll_pkg::CMP_W'(count)) begin
                emit       = 1'b1;
                e_status   = cll_pkg::ST_ABSENT;
                state_next = cll_pkg::S_IDLE;
              end else if (position == cll_pkg::POS_W'(1)) begin
                raddr      = head;
                node_next  = head;
                state_next = cll_pkg::S_RM_HEAD;
              end else begin
                raddr      = head;
                node_next  = head;
                hops_next  = cll_pkg::CNT_W'(position - cll_pkg::POS_W'(2));
                state_next = cll_pkg::S_RM_HOP;
              end
            end
            cll_pkg::CMD_DISPLAY: begin
              if (count == '0) begin
                emit       = 1'b1;
                e_status   = cll_pkg::ST_EMPTY;
                state_next = cll_pkg::S_IDLE;
              end else begin
                raddr      = head;
                node_next  = head;
                rem_next   = count;
                state_next = cll_pkg::S_DISP;
              end
            end
            default: begin
              state_next = cll_pkg::S_IDLE;
            end
          endcase
        end
      end

      cll_pkg::S_APP_LINK: begin
        if (out_free) begin
          lw_en      = 1'b1;
          lw_addr    = node;
          lw_data    = cur;
          emit       = 1'b1;
          state_next = cll_pkg::S_IDLE;
        end
      end

      cll_pkg::S_RM_HEAD: begin
        if (out_free) begin
          used_next[node] = 1'b0;
          count_next      = count - 1'b1;
          if (count == cll_pkg::CNT_W'(1)) begin
            head_next = '0;
            tail_next = '0;
          end else begin
            head_next = link_q;
            lw_en     = 1'b1;
            lw_addr   = tail;
            lw_data   = link_q;
          end
          emit       = 1'b1;
          e_count    = count_next;
          state_next = cll_pkg::S_IDLE;
        end
      end

      cll_pkg::S_RM_HOP: begin
        raddr = link_q;
        if (hops != '0) begin
          node_next = link_q;
          hops_next = hops - 1'b1;
        end else begin
          cur_next   = link_q;
          state_next = cll_pkg::S_RM_NEXT;
        end
      end

      cll_pkg::S_RM_NEXT: begin
        raddr = cur;
        if (out_free) begin
          lw_en          = 1'b1;
          lw_addr        = node;
          lw_data        = link_q;
          used_next[cur] = 1'b0;
          count_next     = count - 1'b1;
          if (cur == tail) begin
            tail_next = node;
          end
          emit       = 1'b1;
          e_count    = count_next;
          state_next = cll_pkg::S_IDLE;
        end
      end

      cll_pkg::S_DISP: begin
        if (out_free) begin
          emit    = 1'b1;
          e_value = value_q;
          e_last  = (rem == cll_pkg::CNT_W'(1));
          if (rem == cll_pkg::CNT_W'(1)) begin
            state_next = cll_pkg::S_IDLE;
          end else begin
            raddr     = link_q;
            node_next = link_q;
            rem_next  = rem - 1'b1;
          end
        end
      end

      default: begin
        state_next = cll_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_status <= e_status;
      out_value  <= e_value;
      out_last   <= e_last;
      out_count  <= e_count;
    end
  end

  assign m_tdata = {3'b000, cll_pkg::OCNT_W'(out_count), out_value};
  assign m_tuser = out_status;
  assign m_tlast = out_last;

endmodule

`default_nettype wire
